### rtl/core/regex_bracket_set_compiler_assert.svh
// assertion macros for the bracket set compiler
`ifndef REGEX_BRACKET_SET_COMPILER_ASSERT_SVH
`define REGEX_BRACKET_SET_COMPILER_ASSERT_SVH
`ifndef SYNTHESIS
`define RBSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RBSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RBSC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RBSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/core/rbsc_pkg.sv
package rbsc_pkg;
  localparam int MaxSetsDefault = 16;
  localparam int MapW = 256;

  typedef struct packed {
    logic [7:0] pattern_byte;
    logic       new_expression;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  set_index;
    logic        set_is_new;
    logic [63:0] map_bits_low;
    logic [63:0] map_bits_second;
    logic [63:0] map_bits_third;
    logic [63:0] map_bits_high;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NOT_SET = 3'd1, ST_BAD_ESC = 3'd2,
    ST_NO_CLOSE = 3'd3, ST_BAD_RANGE = 3'd4, ST_TOO_MANY = 3'd5
  } status_t;

  localparam logic [7:0] ChOpen = 8'h5B;
  localparam logic [7:0] ChClose = 8'h5D;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChHyphen = 8'h2D;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChX = 8'h78;
  localparam logic [7:0] ChF = 8'h66;
  localparam logic [7:0] ChR = 8'h72;
  localparam logic [7:0] ChN = 8'h6E;
  localparam logic [7:0] ChT = 8'h74;

  // parser to datapath commands
  typedef struct packed {
    logic       clear_map;
    logic       fill_map;
    logic       apply;
    logic       negate;
    logic [7:0] lo;
    logic [7:0] hi;
    logic       apply2;
    logic       search_start;
  } dp_cmd_t;

  typedef struct packed {
    logic       done;
    logic       found;
    logic       full;
    logic [7:0] index;
  } dp_stat_t;

  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b0, 4'(b - 8'h30)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b0, 4'(b - 8'h37)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b0, 4'(b - 8'h57)};
    return r;
  endfunction

  function automatic logic [MapW-1:0] range_mask(input logic [7:0] lo, input logic [7:0] hi);
    logic [MapW-1:0] m;
    for (int i = 0; i < MapW; i++) m[i] = (8'(i) >= lo) && (8'(i) <= hi);
    return m;
  endfunction
endpackage

### rtl/core/rbsc_datapath.sv
module rbsc_datapath #(
  parameter int MAX_SETS = rbsc_pkg::MaxSetsDefault
) (
  input  logic clk,
  input  logic rst,
  input  rbsc_pkg::dp_cmd_t cmd,
  input  logic new_expression,
  input  logic new_valid,
  input  logic [4:0] sets_allowed,
  output rbsc_pkg::dp_stat_t stat,
  output logic [rbsc_pkg::MapW-1:0] map
);
  import rbsc_pkg::*;
  localparam int IdxW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int CntW = $clog2(MAX_SETS + 1);

  logic [MapW-1:0] store [MAX_SETS];
  logic [MapW-1:0] rd;
  logic [CntW-1:0] count;
  logic [CntW-1:0] ptr;
  logic searching, rd_valid;
  logic [CntW-1:0] rd_ptr;
  logic [MapW-1:0] m1, m2;
  logic [CntW-1:0] limit;

  assign m1 = range_mask(cmd.lo, cmd.hi);
  assign m2 = range_mask(ChHyphen, ChHyphen);
  assign limit = (32'(sets_allowed) < MAX_SETS) ? CntW'(sets_allowed) : CntW'(MAX_SETS);

  always_ff @(posedge clk) begin
    if (cmd.clear_map) map <= '0;
    else if (cmd.fill_map) map <= '1;
    else if (cmd.apply) begin
      if (cmd.negate) map <= map & ~m1 & ~(cmd.apply2 ? m2 : '0);
      else map <= map | m1 | (cmd.apply2 ? m2 : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (searching && ptr < count) rd <= store[ptr[IdxW-1:0]];
    if (stat.done && !stat.found && !stat.full) store[count[IdxW-1:0]] <= map;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; searching <= 1'b0; rd_valid <= 1'b0; ptr <= '0; rd_ptr <= '0;
      stat <= '0;
    end else begin
      if (stat.done && !stat.found && !stat.full) count <= count + 1'b1;
      else if (new_valid && new_expression) count <= '0;
      if (cmd.search_start) begin
        searching <= 1'b1; ptr <= '0; rd_valid <= 1'b0; stat.done <= 1'b0;
      end else if (searching) begin
        rd_valid <= ptr < count;
        rd_ptr <= ptr;
        if (ptr < count) ptr <= ptr + 1'b1;
        if (rd_valid && rd == map) begin
          searching <= 1'b0; stat.done <= 1'b1; stat.found <= 1'b1;
          stat.full <= 1'b0; stat.index <= 8'(rd_ptr);
        end else if (!(ptr < count) && !rd_valid) begin
          searching <= 1'b0; stat.done <= 1'b1; stat.found <= 1'b0;
          stat.full <= count >= limit; stat.index <= 8'(count);
        end else begin
          stat.done <= 1'b0;
        end
      end else begin
        stat.done <= 1'b0;
      end
    end
  end
endmodule

### rtl/core/rbsc_ctrl.sv
module rbsc_ctrl (
  input  logic clk,
  input  logic rst,
  input  rbsc_pkg::in_item_t in_item,
  input  logic in_fire,
  output logic busy,
  output rbsc_pkg::dp_cmd_t cmd,
  input  rbsc_pkg::dp_stat_t stat,
  input  logic [rbsc_pkg::MapW-1:0] map,
  output logic res_valid,
  output rbsc_pkg::out_item_t res,
  input  logic res_taken
);
  import rbsc_pkg::*;
  typedef enum logic [2:0] {
    P_IDLE, P_FIRST, P_AFTER_NEG, P_NONE, P_GOT1ST, P_HYPHEN
  } phase_t;
  typedef enum logic [1:0] {E_NONE, E_BSL, E_HI, E_LO} esc_t;

  phase_t phase, phase_next;
  esc_t esc, esc_next;
  logic [3:0] hexhi, hexhi_next;
  logic neg, neg_next;
  logic [7:0] pend, pend_next;
  logic waiting;
  logic [1:0] settle;

  logic [7:0] b, c;
  logic [4:0] hv;
  logic take, lit, close, fin, err;
  status_t err_code;

  always_comb begin
    b = in_item.pattern_byte;
    hv = hex_val(b);
    phase_next = phase; esc_next = esc; hexhi_next = hexhi; neg_next = neg;
    pend_next = pend; cmd = '0; cmd.negate = neg;
    take = 1'b0; lit = 1'b0; c = b; fin = 1'b0; err = 1'b0; err_code = ST_NOT_SET;
    close = 1'b0;
    if (phase == P_IDLE) begin
      if (b == ChOpen) begin
        phase_next = P_FIRST; esc_next = E_NONE; hexhi_next = '0; neg_next = 1'b0;
        pend_next = '0; cmd.clear_map = 1'b1;
      end else begin
        err = 1'b1; err_code = ST_NOT_SET;
      end
    end else begin
      unique case (esc)
        E_NONE: begin
          if (b == 8'd0) begin err = 1'b1; err_code = ST_NO_CLOSE; end
          else if (b == ChBslash) esc_next = E_BSL;
          else take = 1'b1;
        end
        E_BSL: begin
          esc_next = E_NONE; lit = 1'b1;
          unique case (b)
            8'd0: begin err = 1'b1; err_code = ST_NO_CLOSE; end
            ChF: begin take = 1'b1; c = 8'h0C; end
            ChR: begin take = 1'b1; c = 8'h0D; end
            ChN: begin take = 1'b1; c = 8'h0A; end
            ChT: begin take = 1'b1; c = 8'h09; end
            ChBslash: begin take = 1'b1; c = ChBslash; end
            ChX: esc_next = E_HI;
            default: begin err = 1'b1; err_code = ST_BAD_ESC; end
          endcase
        end
        E_HI: begin
          if (hv[4]) begin err = 1'b1; err_code = ST_BAD_ESC; end
          else begin hexhi_next = hv[3:0]; esc_next = E_LO; end
        end
        E_LO: begin
          if (hv[4]) begin err = 1'b1; err_code = ST_BAD_ESC; end
          else begin
            esc_next = E_NONE; lit = 1'b1; take = 1'b1; c = {hexhi, hv[3:0]};
          end
        end
        default: ;
      endcase
      close = !lit && c == ChClose;
      if (take) begin
        unique case (phase)
          P_FIRST, P_AFTER_NEG, P_NONE: begin
            if (phase == P_FIRST && !lit && c == ChCaret) begin
              neg_next = 1'b1; cmd.fill_map = 1'b1; phase_next = P_AFTER_NEG;
            end else if (close && phase != P_NONE) begin
              cmd.apply = 1'b1; cmd.lo = c; cmd.hi = c; phase_next = P_NONE;
            end else if (close) fin = 1'b1;
            else begin pend_next = c; phase_next = P_GOT1ST; end
          end
          P_GOT1ST: begin
            if (close) begin
              cmd.apply = 1'b1; cmd.lo = pend; cmd.hi = pend; fin = 1'b1;
            end else if (!lit && c == ChHyphen) phase_next = P_HYPHEN;
            else begin cmd.apply = 1'b1; cmd.lo = pend; cmd.hi = pend; pend_next = c; end
          end
          P_HYPHEN: begin
            if (close) begin
              cmd.apply = 1'b1; cmd.apply2 = 1'b1; cmd.lo = pend; cmd.hi = pend; fin = 1'b1;
            end else if (c < pend) begin err = 1'b1; err_code = ST_BAD_RANGE; end
            else begin cmd.apply = 1'b1; cmd.lo = pend; cmd.hi = c; phase_next = P_NONE; end
          end
          default: phase_next = P_IDLE;
        endcase
      end
    end
    if (err || fin) begin
      phase_next = P_IDLE; esc_next = E_NONE; hexhi_next = '0; neg_next = 1'b0; pend_next = '0;
    end
    if (!in_fire) begin
      phase_next = phase; esc_next = esc; hexhi_next = hexhi; neg_next = neg; pend_next = pend;
      cmd = '0; cmd.negate = neg;
    end else begin
      cmd.search_start = fin;
    end
  end

  assign busy = waiting || res_valid || settle != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE; esc <= E_NONE; hexhi <= '0; neg <= 1'b0; pend <= '0;
      waiting <= 1'b0; res_valid <= 1'b0; settle <= '0;
    end else begin
      phase <= phase_next; esc <= esc_next; hexhi <= hexhi_next; neg <= neg_next;
      pend <= pend_next;
      if (settle != 2'd0) settle <= settle - 2'd1;
      if (res_valid && res_taken) res_valid <= 1'b0;
      if (in_fire && err) begin
        res_valid <= 1'b1;
        res <= '{status: err_code, default: '0};
      end
      if (in_fire && fin) begin
        waiting <= 1'b1; settle <= 2'd1;
      end
      if (waiting && stat.done) begin
        waiting <= 1'b0; res_valid <= 1'b1;
        res.status <= stat.full && !stat.found ? ST_TOO_MANY : ST_OK;
        res.set_index <= (stat.full && !stat.found) ? 4'd0 : stat.index[3:0];
        res.set_is_new <= !stat.found && !stat.full;
        {res.map_bits_high, res.map_bits_third, res.map_bits_second, res.map_bits_low} <= map;
      end
    end
  end
endmodule

### rtl/core/regex_bracket_set_compiler.sv
// one pattern byte per cycle while inside a set, no result for most bytes
// a closing bracket searches the set store one entry a cycle
// errors and non-set bytes give a registered result in the cycle after acceptance
// a new byte is taken only once any result has been taken
// synchronous active-high reset: idle, empty store, sets_allowed 16
module regex_bracket_set_compiler #(
  parameter int MAX_SETS = rbsc_pkg::MaxSetsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  rbsc_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rbsc_pkg::out_item_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [4:0] cfg_data
);
  import rbsc_pkg::*;
`include "regex_bracket_set_compiler_assert.svh"

  logic [4:0] sets_allowed;
  logic busy, in_fire;
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [MapW-1:0] map;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) sets_allowed <= 5'd16;
    else if (cfg_valid) sets_allowed <= cfg_data;
  end

  assign in_ready = !busy;
  assign in_fire = in_valid && in_ready;

  rbsc_ctrl u_ctrl (
    .clk, .rst, .in_item(in_data), .in_fire, .busy, .cmd, .stat, .map,
    .res_valid(out_valid), .res(out_data), .res_taken(out_ready)
  );

  rbsc_datapath #(.MAX_SETS(MAX_SETS)) u_dp (
    .clk, .rst, .cmd, .new_expression(in_data.new_expression), .new_valid(in_fire),
    .sets_allowed, .stat, .map
  );

  `RBSC_ASSERT_IMPL(a_no_accept_while_out, clk, rst, out_valid, !in_ready)
  `RBSC_ASSERT_NEXT(a_search_blocks, clk, rst, in_fire && cmd.search_start, !in_ready)
  `RBSC_ASSERT_IMPL(a_idx_range, clk, rst, out_valid && out_data.set_is_new,
                    out_data.status == ST_OK)
endmodule

### test/rbsc_checker.sv
`timescale 1ns / 1ps
module rbsc_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  rbsc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  rbsc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [4:0]          cfg_data,
  output int                  fail_count,
  output int                  pending
);
  import rbsc_pkg::*;

  typedef enum int {P_IDLE, P_FIRST, P_AFTER_NEG, P_NONE, P_GOT1ST, P_HYPHEN} phase_t;
  typedef enum int {E_NONE, E_BSLASH, E_HEX_HIGH, E_HEX_LOW} esc_t;

  phase_t          phase;
  esc_t            esc;
  logic [3:0]      hex_hi;
  logic            neg;
  logic [7:0]      pend_ch;
  logic [255:0]    wmap;
  logic [255:0]    store [16];
  int              count;
  logic [4:0]      allowed;
  out_item_t       expected_q[$];

  function automatic int hexdig(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "A" && b <= "F") return b - "A" + 10;
    if (b >= "a" && b <= "f") return b - "a" + 10;
    return -1;
  endfunction

  task automatic push_result(status_t st, logic [3:0] idx, logic nw, logic with_map);
    out_item_t r;
    r.status = st;
    r.set_index = idx;
    r.set_is_new = nw;
    {r.map_bits_high, r.map_bits_third, r.map_bits_second, r.map_bits_low} =
      with_map ? wmap : 256'd0;
    expected_q.push_back(r);
  endtask

  task automatic go_idle();
    phase = P_IDLE;
    esc = E_NONE;
    hex_hi = '0;
    neg = 1'b0;
    pend_ch = '0;
  endtask

  task automatic fail_with(status_t st);
    go_idle();
    push_result(st, 4'd0, 1'b0, 1'b0);
  endtask

  task automatic mark(int lo, int hi);
    for (int i = lo; i <= hi; i++) wmap[i] = !neg;
  endtask

  task automatic close_set();
    int lim;
    lim = (allowed < 5'd16) ? int'(allowed) : 16;
    for (int i = 0; i < count; i++) begin
      if (store[i] == wmap) begin
        push_result(ST_OK, 4'(i), 1'b0, 1'b1);
        go_idle();
        return;
      end
    end
    if (count >= lim) begin
      push_result(ST_TOO_MANY, 4'd0, 1'b0, 1'b1);
    end else begin
      store[count] = wmap;
      push_result(ST_OK, 4'(count), 1'b1, 1'b1);
      count++;
    end
    go_idle();
  endtask

  task automatic take_char(logic [7:0] c, bit lit);
    bit cl;
    cl = !lit && c == ChClose;
    if (phase == P_FIRST && !lit && c == ChCaret) begin
      neg = 1'b1;
      wmap = '1;
      phase = P_AFTER_NEG;
      return;
    end
    case (phase)
      P_FIRST, P_AFTER_NEG, P_NONE: begin
        if (cl && phase != P_NONE) begin
          mark(c, c);
          phase = P_NONE;
        end else if (cl) begin
          close_set();
        end else begin
          pend_ch = c;
          phase = P_GOT1ST;
        end
      end
      P_GOT1ST: begin
        if (cl) begin
          mark(pend_ch, pend_ch);
          close_set();
        end else if (!lit && c == ChHyphen) begin
          phase = P_HYPHEN;
        end else begin
          mark(pend_ch, pend_ch);
          pend_ch = c;
        end
      end
      P_HYPHEN: begin
        if (cl) begin
          mark(pend_ch, pend_ch);
          mark(ChHyphen, ChHyphen);
          close_set();
        end else if (c < pend_ch) begin
          fail_with(ST_BAD_RANGE);
        end else begin
          mark(pend_ch, c);
          phase = P_NONE;
        end
      end
      default: go_idle();
    endcase
  endtask

  task automatic predict(in_item_t it);
    logic [7:0] b;
    int d;
    b = it.pattern_byte;
    if (it.new_expression) count = 0;
    if (phase == P_IDLE) begin
      if (b == ChOpen) begin
        go_idle();
        phase = P_FIRST;
        wmap = '0;
      end else begin
        push_result(ST_NOT_SET, 4'd0, 1'b0, 1'b0);
      end
      return;
    end
    case (esc)
      E_NONE: begin
        if (b == 8'h00) fail_with(ST_NO_CLOSE);
        else if (b == ChBslash) esc = E_BSLASH;
        else take_char(b, 1'b0);
      end
      E_BSLASH: begin
        esc = E_NONE;
        case (b)
          8'h00: fail_with(ST_NO_CLOSE);
          ChF: take_char(8'h0C, 1'b1);
          ChR: take_char(8'h0D, 1'b1);
          ChN: take_char(8'h0A, 1'b1);
          ChT: take_char(8'h09, 1'b1);
          ChBslash: take_char(ChBslash, 1'b1);
          ChX: esc = E_HEX_HIGH;
          default: fail_with(ST_BAD_ESC);
        endcase
      end
      E_HEX_HIGH: begin
        d = hexdig(b);
        if (d < 0) fail_with(ST_BAD_ESC);
        else begin
          hex_hi = 4'(d);
          esc = E_HEX_LOW;
        end
      end
      default: begin
        d = hexdig(b);
        if (d < 0) fail_with(ST_BAD_ESC);
        else begin
          esc = E_NONE;
          take_char({hex_hi, 4'(d)}, 1'b1);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      go_idle();
      wmap = '0;
      count = 0;
      allowed = 5'd16;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) allowed = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected item: status %0d", out_data.status);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (out_data.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_data.status);
            fail_count++;
          end
          if (out_data.set_index !== e.set_index) begin
            $error("set_index expected %0d actual %0d", e.set_index, out_data.set_index);
            fail_count++;
          end
          if (out_data.set_is_new !== e.set_is_new) begin
            $error("set_is_new expected %0d actual %0d", e.set_is_new, out_data.set_is_new);
            fail_count++;
          end
          if (out_data.map_bits_low !== e.map_bits_low) begin
            $error("map_bits_low expected %h actual %h", e.map_bits_low,
                   out_data.map_bits_low);
            fail_count++;
          end
          if (out_data.map_bits_second !== e.map_bits_second) begin
            $error("map_bits_second expected %h actual %h", e.map_bits_second,
                   out_data.map_bits_second);
            fail_count++;
          end
          if (out_data.map_bits_third !== e.map_bits_third) begin
            $error("map_bits_third expected %h actual %h", e.map_bits_third,
                   out_data.map_bits_third);
            fail_count++;
          end
          if (out_data.map_bits_high !== e.map_bits_high) begin
            $error("map_bits_high expected %h actual %h", e.map_bits_high,
                   out_data.map_bits_high);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) predict(in_data);
    end
    pending = expected_q.size();
  end
endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb;
  import rbsc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  byte unsigned pat[$];
  logic        fresh[$];

  regex_bracket_set_compiler dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  rbsc_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL regex_bracket_set_compiler");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  task automatic add(byte unsigned b, logic ne = 1'b0);
    pat.push_back(b);
    fresh.push_back(ne);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) add(s[i]);
  endtask

  task automatic send_all();
    while (pat.size() > 0) begin
      @(negedge clk);
      while ($urandom_range(99) < send_idle) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_data <= '{pattern_byte: pat.pop_front(), new_expression: fresh.pop_front()};
      do @(posedge clk); while (!in_ready);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_cfg(logic [4:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic byte unsigned rand_char();
    int k;
    k = $urandom_range(9);
    if (k < 6) return 8'($urandom_range(255, 1));
    case (k)
      6: return 8'("a" + $urandom_range(25));
      7: return "-";
      8: return "]";
      default: return "^";
    endcase
  endfunction

  task automatic rand_escape();
    string hx;
    int k;
    hx = "0123456789abcdefABCDEFgz";
    k = $urandom_range(9);
    add("\\");
    case (k)
      0: add("f");
      1: add("r");
      2: add("n");
      3: add("t");
      4: add("\\");
      5: add(8'($urandom_range(255)));
      default: begin
        add("x");
        add(hx[$urandom_range(k == 9 ? 23 : 21)]);
        add(hx[$urandom_range(k == 8 ? 23 : 21)]);
      end
    endcase
  endtask

  task automatic rand_set();
    int n;
    byte unsigned a;
    add("[", $urandom_range(15) == 0);
    if ($urandom_range(3) == 0) add("^");
    if ($urandom_range(5) == 0) add("]");
    n = $urandom_range(4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: rand_escape();
        1: begin
          a = 8'($urandom_range(250, 1));
          add(a);
          add("-");
          add($urandom_range(7) == 0 ? 8'($urandom_range(255, 1)) :
              8'($urandom_range(255, a)));
        end
        2: add(8'("a" + $urandom_range(3)));
        default: add(rand_char());
      endcase
    end
    case ($urandom_range(19))
      0: add(8'h00);
      1: begin add("-"); add("]"); end
      default: add("]");
    endcase
  endtask

  task automatic random_phase(int items);
    int target;
    target = pat.size() + items;
    while (pat.size() < target) begin
      if ($urandom_range(9) < 8) rand_set();
      else add(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    send_all();
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    add(8'h00); add(8'hFF); add("a", 1'b1);
    add_str("[a-z\\x41]"); add_str("[^]x-]"); add_str("[]]"); add_str("[a-z\\x41]");
    add_str("[\\f\\r\\n\\t\\\\\\xfF]"); add_str("[\\q]"); add_str("[\\xg"); add_str("[z-a]");
    add_str("[\\x00-\\xff]"); add("["); add("\\"); add(8'h00); add("["); add(8'h00);
    send_all();
    drain();
    write_cfg(5'd1);
    add_str("[a]"); add_str("[b]"); add_str("[a]");
    send_all();
    drain();
    write_cfg(5'd0);
    add_str("[c]"); add("[", 1'b1); add_str("q]");
    send_all();
    drain();
    write_cfg(5'd31);
    send_idle = 19; recv_idle = 49;
    random_phase(520);
    write_cfg(5'd5);
    send_idle = 49; recv_idle = 19;
    random_phase(520);
    write_cfg(5'd16);
    send_idle = 0; recv_idle = 0;
    random_phase(480);
    if (fail_count == 0) $display("PASS regex_bracket_set_compiler");
    else $display("FAIL regex_bracket_set_compiler");
    $finish;
  end
endmodule
